### rtl/core/jcd_pkg.sv
// Shared types, codes and byte constants of the Japanese charset detector.
package jcd_pkg;

	typedef enum logic [2:0] {
		DET_NONE = 3'd0,
		DET_EUC  = 3'd1,
		DET_ISO  = 3'd2,
		DET_SJIS = 3'd3,
		DET_UTF8 = 3'd4
	} det_code_t;

	// Candidate and confirmed mask bit positions
	localparam int unsigned MB_EUC  = 0;
	localparam int unsigned MB_ISO  = 1;
	localparam int unsigned MB_SJIS = 2;
	localparam int unsigned MB_UTF8 = 3;

	localparam logic [3:0] MASK_EUC  = 4'b0001;
	localparam logic [3:0] MASK_ISO  = 4'b0010;
	localparam logic [3:0] MASK_SJIS = 4'b0100;
	localparam logic [3:0] MASK_UTF8 = 4'b1000;

	localparam logic CMD_DATA   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [7:0] BYTE_NUL      = 8'h00;
	localparam logic [7:0] BYTE_ESC      = 8'h1B;
	localparam logic [7:0] BYTE_DOLLAR   = 8'h24;
	localparam logic [7:0] BYTE_AT       = 8'h40;
	localparam logic [7:0] BYTE_B        = 8'h42;
	localparam logic [7:0] BYTE_ASCII_HI = 8'h7E;
	localparam logic [7:0] BYTE_HIGH     = 8'h80;
	localparam logic [7:0] BYTE_SJIS_L1  = 8'h81;
	localparam logic [7:0] BYTE_SS2      = 8'h8E;
	localparam logic [7:0] BYTE_SS3      = 8'h8F;
	localparam logic [7:0] BYTE_SJIS_L1E = 8'h9F;
	localparam logic [7:0] BYTE_KANA_LO  = 8'hA1;
	localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
	localparam logic [7:0] BYTE_U2_LO    = 8'hC0;
	localparam logic [7:0] BYTE_KANA_HI  = 8'hDF;
	localparam logic [7:0] BYTE_U3_LO    = 8'hE0;
	localparam logic [7:0] BYTE_U3_HI    = 8'hEF;
	localparam logic [7:0] BYTE_SJIS_THI = 8'hFC;
	localparam logic [7:0] BYTE_EUC_HI   = 8'hFE;
	localparam logic [7:0] BYTE_FF       = 8'hFF;

	typedef struct packed {
		logic       cmd;
		logic [7:0] text_byte;
	} jcd_in_t;

	typedef struct packed {
		logic [2:0] detected;
		logic       is_binary;
	} jcd_out_t;

	function automatic logic single_bit(input logic [3:0] m);
		return (m != 4'd0) && ((m & (m - 4'd1)) == 4'd0);
	endfunction

	function automatic det_code_t code_of(input logic [3:0] m);
		det_code_t c;
		unique case (m)
			MASK_EUC:  c = DET_EUC;
			MASK_ISO:  c = DET_ISO;
			MASK_SJIS: c = DET_SJIS;
			MASK_UTF8: c = DET_UTF8;
			default:   c = DET_NONE;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/jcd_stream_if.sv
// Valid/ready word channel with a typed payload.
interface jcd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/japanese_charset_detector_unit.sv
// Japanese charset detector: EUC-JP, ISO-2022-JP, Shift-JIS and UTF-8 recognizers.
// A word accepted into the input register has its result captured in the result register.
// Throughput: one word per cycle while the result register is free; the recognizer state
// updates in a single pass between the input register and the result register.
// Reset (arst_n low): recognizers to their ascii states, all four candidates
// set, nothing confirmed, stream clean and not binary, both stages empty.
module japanese_charset_detector_unit (
	input  logic         clk,
	input  logic         arst_n,
	jcd_stream_if.sink   req,
	jcd_stream_if.source rsp
);
	import jcd_pkg::*;

	typedef enum logic [2:0] {
		EUC_ASCII  = 3'd0,
		EUC_LEAD   = 3'd1,
		EUC_SS2    = 3'd2,
		EUC_SS3    = 3'd3,
		EUC_SS3_2  = 3'd4
	} euc_state_t;

	typedef enum logic [1:0] {
		ISO_ASCII  = 2'd0,
		ISO_ESC    = 2'd1,
		ISO_ESC_DL = 2'd2
	} iso_state_t;

	typedef enum logic {
		SJIS_ASCII = 1'b0,
		SJIS_LEAD  = 1'b1
	} sjis_state_t;

	typedef enum logic [1:0] {
		UTF8_IDLE  = 2'd0,
		UTF8_LAST  = 2'd1,
		UTF8_TWO   = 2'd2,
		UTF8_LAST3 = 2'd3
	} utf8_state_t;

	jcd_in_t     req_s1;
	logic        valid_s1;
	jcd_out_t    rsp_s2;
	logic        valid_s2;

	euc_state_t  euc_q, euc_d;
	iso_state_t  iso_q, iso_d;
	sjis_state_t sjis_q, sjis_d;
	utf8_state_t utf8_q, utf8_d;
	logic [3:0]  cand_q, cand_d;
	logic [3:0]  poss_q, poss_d;
	logic        clean_q, clean_d;
	logic        binary_q, binary_d;

	logic [3:0]  conf;
	logic [3:0]  kill;
	det_code_t   det;
	logic        is_bin;
	logic [7:0]  c;
	logic        s2_free;
	logic        adv;

	assign s2_free   = !valid_s2 || rsp.ready;
	assign adv       = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;
	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;
	assign c         = req_s1.text_byte;

	always_comb begin
		euc_d    = euc_q;
		iso_d    = iso_q;
		sjis_d   = sjis_q;
		utf8_d   = utf8_q;
		clean_d  = clean_q;
		binary_d = binary_q;
		conf     = 4'd0;
		kill     = 4'd0;
		det      = DET_NONE;

		if (binary_q || cand_q == 4'd0) begin
			det = DET_NONE;
		end else if (req_s1.cmd == CMD_FINISH) begin
			if (single_bit(poss_q)) begin
				det = code_of(poss_q);
			end else if (clean_q) begin
				det = DET_NONE;
			end else if (poss_q[MB_UTF8]) begin
				det = DET_UTF8;
			end else if (poss_q[MB_SJIS]) begin
				det = DET_SJIS;
			end else if (poss_q[MB_EUC]) begin
				det = DET_EUC;
			end else if (poss_q[MB_ISO]) begin
				det = DET_ISO;
			end
		end else if (c == BYTE_NUL || c == BYTE_FF) begin
			binary_d = 1'b1;
		end else begin
			if (c >= BYTE_HIGH) begin
				clean_d = 1'b0;
			end

			if (cand_q[MB_EUC]) begin
				unique case (euc_q)
					EUC_ASCII: begin
						if (c <= BYTE_ASCII_HI) euc_d = EUC_ASCII;
						else if (c >= BYTE_KANA_LO && c <= BYTE_EUC_HI) euc_d = EUC_LEAD;
						else if (c == BYTE_SS2) euc_d = EUC_SS2;
						else if (c == BYTE_SS3) euc_d = EUC_SS3;
						else kill[MB_EUC] = 1'b1;
					end
					EUC_LEAD, EUC_SS3_2: begin
						if (c >= BYTE_KANA_LO && c <= BYTE_EUC_HI) begin
							conf[MB_EUC] = 1'b1;
							euc_d        = EUC_ASCII;
						end else begin
							kill[MB_EUC] = 1'b1;
						end
					end
					EUC_SS2: begin
						if (c >= BYTE_KANA_LO && c <= BYTE_KANA_HI) begin
							conf[MB_EUC] = 1'b1;
							euc_d        = EUC_ASCII;
						end else begin
							kill[MB_EUC] = 1'b1;
						end
					end
					EUC_SS3: begin
						if (c >= BYTE_KANA_LO && c <= BYTE_EUC_HI) euc_d = EUC_SS3_2;
						else kill[MB_EUC] = 1'b1;
					end
					default: euc_d = EUC_ASCII;
				endcase
			end

			if (cand_q[MB_ISO]) begin
				unique case (iso_q)
					ISO_ASCII: begin
						if (c == BYTE_ESC) iso_d = ISO_ESC;
						else if (c >= BYTE_HIGH) kill[MB_ISO] = 1'b1;
					end
					ISO_ESC: begin
						if (c == BYTE_DOLLAR) iso_d = ISO_ESC_DL;
						else if (c == BYTE_ESC) iso_d = ISO_ESC;
						else if (c < BYTE_HIGH) iso_d = ISO_ASCII;
						else kill[MB_ISO] = 1'b1;
					end
					ISO_ESC_DL: begin
						if (c == BYTE_B || c == BYTE_AT) begin
							conf[MB_ISO] = 1'b1;
							iso_d        = ISO_ASCII;
						end else begin
							kill[MB_ISO] = 1'b1;
						end
					end
					default: iso_d = ISO_ASCII;
				endcase
			end

			if (cand_q[MB_SJIS]) begin
				unique case (sjis_q)
					SJIS_ASCII: begin
						if (c <= BYTE_ASCII_HI) begin
							sjis_d = SJIS_ASCII;
						end else if (c >= BYTE_KANA_LO && c <= BYTE_KANA_HI) begin
							conf[MB_SJIS] = 1'b1;
						end else if ((c >= BYTE_SJIS_L1 && c <= BYTE_SJIS_L1E) ||
								(c >= BYTE_U3_LO && c <= BYTE_U3_HI)) begin
							sjis_d = SJIS_LEAD;
						end else begin
							kill[MB_SJIS] = 1'b1;
						end
					end
					SJIS_LEAD: begin
						if (c <= BYTE_ASCII_HI || (c >= BYTE_HIGH && c <= BYTE_SJIS_THI)) begin
							conf[MB_SJIS] = 1'b1;
							sjis_d        = SJIS_ASCII;
						end else begin
							kill[MB_SJIS] = 1'b1;
						end
					end
					default: sjis_d = SJIS_ASCII;
				endcase
			end

			if (cand_q[MB_UTF8]) begin
				if (utf8_q == UTF8_IDLE) begin
					if (c <= BYTE_ASCII_HI) utf8_d = UTF8_IDLE;
					else if (c >= BYTE_U2_LO && c <= BYTE_KANA_HI) utf8_d = UTF8_LAST;
					else if (c >= BYTE_U3_LO && c <= BYTE_U3_HI) utf8_d = UTF8_TWO;
					else kill[MB_UTF8] = 1'b1;
				end else if (c >= BYTE_HIGH && c <= BYTE_CONT_HI) begin
					if (utf8_q == UTF8_TWO) begin
						utf8_d = UTF8_LAST3;
					end else begin
						conf[MB_UTF8] = 1'b1;
						utf8_d        = UTF8_IDLE;
					end
				end else begin
					kill[MB_UTF8] = 1'b1;
				end
			end
		end

		cand_d = cand_q & ~kill;
		poss_d = (poss_q | conf) & ~kill;

		if (!(binary_q || cand_q == 4'd0) && req_s1.cmd == CMD_DATA &&
				c != BYTE_NUL && c != BYTE_FF &&
				single_bit(cand_d) && cand_d == poss_d) begin
			det = code_of(cand_d);
		end

		is_bin = binary_d || cand_d == 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (req.valid && req.ready) || (valid_s1 && !s2_free);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= adv || (valid_s2 && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2.detected  <= det;
			rsp_s2.is_binary <= is_bin;
		end
	end

	// Advance recognizer state once per word leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euc_q    <= EUC_ASCII;
			iso_q    <= ISO_ASCII;
			sjis_q   <= SJIS_ASCII;
			utf8_q   <= UTF8_IDLE;
			cand_q   <= 4'hF;
			poss_q   <= 4'h0;
			clean_q  <= 1'b1;
			binary_q <= 1'b0;
		end else if (adv) begin
			euc_q    <= euc_d;
			iso_q    <= iso_d;
			sjis_q   <= sjis_d;
			utf8_q   <= utf8_d;
			cand_q   <= cand_d;
			poss_q   <= poss_d;
			clean_q  <= clean_d;
			binary_q <= binary_d;
		end
	end

	a_cand_only_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cand_q & ~$past(cand_q)) == 4'd0)
		else $error("candidate mask gained a bit");

	a_poss_within_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(poss_q & ~cand_q) == 4'd0)
		else $error("confirmed encoding not among candidates");

	a_binary_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		binary_q |=> binary_q)
		else $error("binary flag dropped");

	a_binary_undecided: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rsp_s2.is_binary) |-> (rsp_s2.detected == DET_NONE))
		else $error("binary result carries a decision");

endmodule
